// ----- rtl/core/kdj_pkg.sv -----
// ----------------------------------------------------------------------------
// kdj_pkg
// Shared types and constants of the KDJ stochastic oscillator.
// ----------------------------------------------------------------------------
package kdj_pkg;

	localparam int PRICE_BITS    = 32;
	localparam int FRACTION_BITS = 16;
	localparam int KD_BITS       = 23;
	localparam int J_BITS        = 28;
	localparam int WL_BITS       = 7;
	localparam int SL_BITS       = 8;
	localparam int JW_BITS       = 12;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 12;

	// long division: quotient bits, numerator bits
	localparam int DIV_Q_BITS  = KD_BITS + 1;
	localparam int SCALE_BITS  = PRICE_BITS + 7;
	localparam int RATIO_SHIFT = FRACTION_BITS + 1;
	localparam int DIV_N_BITS  = SCALE_BITS + RATIO_SHIFT;

	localparam logic [KD_BITS-1:0] FIFTY       = KD_BITS'(50 << FRACTION_BITS);
	localparam logic [KD_BITS-1:0] ONE_HUNDRED = KD_BITS'(100 << FRACTION_BITS);
	localparam logic signed [J_BITS-1:0] J_LIMIT = J_BITS'(1600 << FRACTION_BITS);

	localparam logic [WL_BITS-1:0] WL_RESET = WL_BITS'(9);
	localparam logic [SL_BITS-1:0] SL_RESET = SL_BITS'(3);
	localparam logic [JW_BITS-1:0] JW_RESET = JW_BITS'(768);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_WINDOW  = 2'd0,
		CFG_SMOOTH  = 2'd1,
		CFG_JWEIGHT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [WL_BITS-1:0] window_length;
		logic [SL_BITS-1:0] smoothing_length;
		logic [JW_BITS-1:0] j_weight;
	} cfg_t;

	typedef struct packed {
		logic [PRICE_BITS-1:0] bar_high;
		logic [PRICE_BITS-1:0] bar_low;
		logic [PRICE_BITS-1:0] bar_close;
	} bar_t;

	typedef struct packed {
		logic                     result_valid;
		logic [KD_BITS-1:0]       k_line;
		logic [KD_BITS-1:0]       d_line;
		logic signed [J_BITS-1:0] j_line;
	} result_t;

	typedef struct packed {
		bar_t bar;
		logic full;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STORE,
		ST_SCAN,
		ST_CLASS,
		ST_SCALE,
		ST_RSV_GO,
		ST_RSV_WAIT,
		ST_K_MUL,
		ST_K_GO,
		ST_K_WAIT,
		ST_D_MUL,
		ST_D_GO,
		ST_D_WAIT,
		ST_J_MUL,
		ST_J_SUM,
		ST_OUT
	} back_state_t;

endpackage

// ----- rtl/core/kdj_ram.sv -----
// ----------------------------------------------------------------------------
// kdj_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kdj_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/kdj_queue.sv -----
// ----------------------------------------------------------------------------
// kdj_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module kdj_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kdj_pkg::job_t push_job,
	input  logic          pop,
	output kdj_pkg::job_t head,
	output logic          full,
	output logic          empty
);

	kdj_pkg::job_t ent_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/core/kdj_front.sv -----
// ----------------------------------------------------------------------------
// kdj_front
// Config registers, bar intake and window-fill tracking.
// ----------------------------------------------------------------------------
module kdj_front #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  kdj_pkg::bar_t                       in_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [kdj_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [kdj_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output kdj_pkg::cfg_t                       cfg,
	output logic [$clog2(WINDOW_MAX+1)-1:0]     win_len,
	output logic                                push,
	output kdj_pkg::job_t                       push_job,
	input  logic                                q_full
);

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);

	kdj_pkg::cfg_t    cfg_q;
	logic [CNT_W-1:0] seen_q;
	logic [CNT_W-1:0] seen_nxt;

	assign cfg       = cfg_q;
	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign push      = in_valid && !q_full;

	always_comb begin
		if (cfg_q.window_length == '0) begin
			win_len = CNT_W'(1);
		end else if (int'(cfg_q.window_length) > WINDOW_MAX) begin
			win_len = CNT_W'(WINDOW_MAX);
		end else begin
			win_len = CNT_W'(cfg_q.window_length);
		end
		seen_nxt      = (seen_q < win_len) ? seen_q + 1'b1 : win_len;
		push_job.bar  = in_data;
		push_job.full = seen_nxt == win_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_length    <= kdj_pkg::WL_RESET;
			cfg_q.smoothing_length <= kdj_pkg::SL_RESET;
			cfg_q.j_weight         <= kdj_pkg::JW_RESET;
			seen_q                 <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					kdj_pkg::CFG_WINDOW: begin
						cfg_q.window_length <= cfg_data[kdj_pkg::WL_BITS-1:0];
					end
					kdj_pkg::CFG_SMOOTH: begin
						cfg_q.smoothing_length <= cfg_data[kdj_pkg::SL_BITS-1:0];
					end
					kdj_pkg::CFG_JWEIGHT: begin
						cfg_q.j_weight <= cfg_data[kdj_pkg::JW_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (push) begin
				seen_q <= seen_nxt;
			end
		end
	end

endmodule

// ----- rtl/core/kdj_div.sv -----
// ----------------------------------------------------------------------------
// kdj_div
// Restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module kdj_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [kdj_pkg::DIV_N_BITS-1:0]    num,
	input  logic [kdj_pkg::PRICE_BITS-1:0]    den,
	output logic                              busy,
	output logic [kdj_pkg::DIV_Q_BITS-1:0]    quo
);

	localparam int PB    = kdj_pkg::PRICE_BITS;
	localparam int QB    = kdj_pkg::DIV_Q_BITS;
	localparam int STEPS = QB / 2;
	localparam int CW    = $clog2(STEPS + 1);

	// remainder always below den; numerator top bits are below den by use
	logic [PB-1:0] rem_q;
	logic [PB-1:0] den_q;
	logic [QB-1:0] lo_q;
	logic [QB-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic [PB:0]   ra;
	logic [PB:0]   rb;
	logic [PB-1:0] rem_a;
	logic [PB-1:0] rem_b;
	logic          ge_a;
	logic          ge_b;

	assign busy = cnt_q != '0;
	assign quo  = quo_q;

	always_comb begin
		ra    = {rem_q, lo_q[QB-1]};
		ge_a  = ra >= {1'b0, den_q};
		rem_a = ge_a ? PB'(ra - {1'b0, den_q}) : ra[PB-1:0];
		rb    = {rem_a, lo_q[QB-2]};
		ge_b  = rb >= {1'b0, den_q};
		rem_b = ge_b ? PB'(rb - {1'b0, den_q}) : rb[PB-1:0];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[kdj_pkg::DIV_N_BITS-1 -: PB];
			lo_q  <= num[QB-1:0];
			den_q <= den;
		end else if (busy) begin
			rem_q <= rem_b;
			lo_q  <= {lo_q[QB-3:0], 2'b00};
			quo_q <= {quo_q[QB-3:0], ge_a, ge_b};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- rtl/core/kdj_back.sv -----
// ----------------------------------------------------------------------------
// kdj_back
// Ring storage, window scan, RSV, K/D smoothing, J and result register.
// ----------------------------------------------------------------------------
module kdj_back #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  kdj_pkg::cfg_t                   cfg,
	input  logic [$clog2(WINDOW_MAX+1)-1:0] win_len,
	input  kdj_pkg::job_t                   job,
	input  logic                            q_empty,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_stall,
	output kdj_pkg::result_t                out_data
);

	localparam int PB    = kdj_pkg::PRICE_BITS;
	localparam int KB    = kdj_pkg::KD_BITS;
	localparam int JB    = kdj_pkg::J_BITS;
	localparam int SB    = kdj_pkg::SL_BITS;
	localparam int NB    = kdj_pkg::DIV_N_BITS;
	localparam int QB    = kdj_pkg::DIV_Q_BITS;
	localparam int MB    = SB + KB;
	localparam int PTR_W = $clog2(WINDOW_MAX);
	localparam int CNT_W = $clog2(WINDOW_MAX + 1);

	kdj_pkg::back_state_t state_q, state_d;

	kdj_pkg::job_t            job_q;
	logic [PTR_W-1:0]         wr_ptr_q;
	logic [PTR_W-1:0]         rd_idx_q;
	logic [CNT_W-1:0]         issue_q;
	logic                     rd_valid_s1;
	logic [PB-1:0]            hh_q;
	logic [PB-1:0]            ll_q;
	logic [PB-1:0]            diff_q;
	logic [PB-1:0]            span_q;
	logic [kdj_pkg::SCALE_BITS-1:0] t_q;
	logic [KB-1:0]            rsv_q;
	logic [KB-1:0]            k_q;
	logic [KB-1:0]            d_q;
	logic [MB-1:0]            prod_q;
	logic signed [KB+13:0]    pj_q;
	logic signed [KB+13:0]    pd_q;
	logic signed [JB-1:0]     j_q;
	kdj_pkg::result_t         out_q;
	logic                     out_valid_q;

	logic [PB-1:0] hi_rd;
	logic [PB-1:0] lo_rd;
	logic          ram_we;
	logic          rd_en;
	logic [SB-1:0] s_eff;
	logic          div_start;
	logic [NB-1:0] div_num;
	logic [PB-1:0] div_den;
	logic          div_busy;
	logic [QB-1:0] div_quo;
	logic          out_load;
	logic signed [KB+14:0] jsum;
	logic signed [KB+6:0]  jrnd;
	kdj_pkg::result_t res;

	kdj_ram #(.WIDTH(PB), .DEPTH(WINDOW_MAX)) u_high_ring (
		.clk(clk), .we(ram_we), .waddr(wr_ptr_q), .wdata(job_q.bar.bar_high),
		.raddr(rd_idx_q), .rdata(hi_rd)
	);

	kdj_ram #(.WIDTH(PB), .DEPTH(WINDOW_MAX)) u_low_ring (
		.clk(clk), .we(ram_we), .waddr(wr_ptr_q), .wdata(job_q.bar.bar_low),
		.raddr(rd_idx_q), .rdata(lo_rd)
	);

	kdj_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .quo(div_quo)
	);

	assign s_eff     = (cfg.smoothing_length == '0) ? SB'(1) : cfg.smoothing_length;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		jsum = (KB+15)'(pj_q) - (KB+15)'(pd_q) + (KB+15)'(128);
		jrnd = (KB+7)'(jsum >>> 8);
	end

	always_comb begin
		res.result_valid = job_q.full;
		res.k_line       = job_q.full ? k_q : '0;
		res.d_line       = job_q.full ? d_q : '0;
		res.j_line       = job_q.full ? j_q : '0;
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		ram_we    = 1'b0;
		rd_en     = 1'b0;
		div_start = 1'b0;
		div_num   = {t_q, (kdj_pkg::RATIO_SHIFT)'(0)};
		div_den   = span_q;
		out_load  = 1'b0;
		unique case (state_q)
			kdj_pkg::ST_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = kdj_pkg::ST_STORE;
				end
			end
			kdj_pkg::ST_STORE: begin
				ram_we  = 1'b1;
				state_d = job_q.full ? kdj_pkg::ST_SCAN : kdj_pkg::ST_OUT;
			end
			kdj_pkg::ST_SCAN: begin
				rd_en = issue_q < win_len;
				if (!rd_en && !rd_valid_s1) begin
					state_d = kdj_pkg::ST_CLASS;
				end
			end
			kdj_pkg::ST_CLASS: begin
				state_d = kdj_pkg::ST_K_MUL;
				if (hh_q > ll_q && job_q.bar.bar_close < hh_q && job_q.bar.bar_close > ll_q) begin
					state_d = kdj_pkg::ST_SCALE;
				end
			end
			kdj_pkg::ST_SCALE: begin
				state_d = kdj_pkg::ST_RSV_GO;
			end
			kdj_pkg::ST_RSV_GO: begin
				div_start = 1'b1;
				state_d   = kdj_pkg::ST_RSV_WAIT;
			end
			kdj_pkg::ST_RSV_WAIT: begin
				if (!div_busy) begin
					state_d = kdj_pkg::ST_K_MUL;
				end
			end
			kdj_pkg::ST_K_MUL: begin
				state_d = kdj_pkg::ST_K_GO;
			end
			kdj_pkg::ST_K_GO: begin
				div_start = 1'b1;
				div_num   = NB'(prod_q) + NB'(rsv_q) + NB'(s_eff >> 1);
				div_den   = PB'(s_eff);
				state_d   = kdj_pkg::ST_K_WAIT;
			end
			kdj_pkg::ST_K_WAIT: begin
				if (!div_busy) begin
					state_d = kdj_pkg::ST_D_MUL;
				end
			end
			kdj_pkg::ST_D_MUL: begin
				state_d = kdj_pkg::ST_D_GO;
			end
			kdj_pkg::ST_D_GO: begin
				div_start = 1'b1;
				div_num   = NB'(prod_q) + NB'(k_q) + NB'(s_eff >> 1);
				div_den   = PB'(s_eff);
				state_d   = kdj_pkg::ST_D_WAIT;
			end
			kdj_pkg::ST_D_WAIT: begin
				if (!div_busy) begin
					state_d = kdj_pkg::ST_J_MUL;
				end
			end
			kdj_pkg::ST_J_MUL: begin
				state_d = kdj_pkg::ST_J_SUM;
			end
			kdj_pkg::ST_J_SUM: begin
				state_d = kdj_pkg::ST_OUT;
			end
			kdj_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = kdj_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kdj_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kdj_pkg::ST_IDLE;
			wr_ptr_q    <= '0;
			rd_valid_s1 <= 1'b0;
			k_q         <= kdj_pkg::FIFTY;
			d_q         <= kdj_pkg::FIFTY;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_en;
			if (ram_we) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(WINDOW_MAX - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (state_q == kdj_pkg::ST_K_WAIT && !div_busy) begin
				k_q <= div_quo[KB-1:0];
			end
			if (state_q == kdj_pkg::ST_D_WAIT && !div_busy) begin
				d_q <= div_quo[KB-1:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
		if (ram_we) begin
			rd_idx_q <= wr_ptr_q;
			issue_q  <= '0;
			hh_q     <= '0;
			ll_q     <= '1;
		end
		if (rd_en) begin
			rd_idx_q <= (rd_idx_q == '0) ? PTR_W'(WINDOW_MAX - 1) : rd_idx_q - 1'b1;
			issue_q  <= issue_q + 1'b1;
		end
		if (rd_valid_s1) begin
			if (hi_rd > hh_q) begin
				hh_q <= hi_rd;
			end
			if (lo_rd < ll_q) begin
				ll_q <= lo_rd;
			end
		end
		if (state_q == kdj_pkg::ST_CLASS) begin
			diff_q <= job_q.bar.bar_close - ll_q;
			span_q <= hh_q - ll_q;
			if (hh_q == ll_q) begin
				rsv_q <= kdj_pkg::FIFTY;
			end else if (hh_q < ll_q) begin
				rsv_q <= (job_q.bar.bar_close > hh_q && job_q.bar.bar_close >= ll_q) ?
					kdj_pkg::ONE_HUNDRED : '0;
			end else if (job_q.bar.bar_close >= hh_q) begin
				rsv_q <= kdj_pkg::ONE_HUNDRED;
			end else begin
				rsv_q <= '0;
			end
		end
		if (state_q == kdj_pkg::ST_SCALE) begin
			t_q <= kdj_pkg::SCALE_BITS'(diff_q) * kdj_pkg::SCALE_BITS'(100);
		end
		if (state_q == kdj_pkg::ST_RSV_WAIT && !div_busy) begin
			rsv_q <= KB'(((QB+1)'(div_quo) + (QB+1)'(1)) >> 1);
		end
		if (state_q == kdj_pkg::ST_K_MUL) begin
			prod_q <= MB'(s_eff - 1'b1) * MB'(k_q);
		end
		if (state_q == kdj_pkg::ST_D_MUL) begin
			prod_q <= MB'(s_eff - 1'b1) * MB'(d_q);
		end
		if (state_q == kdj_pkg::ST_J_MUL) begin
			pj_q <= (KB+14)'($signed({1'b0, cfg.j_weight}) * $signed({1'b0, k_q}));
			pd_q <= (KB+14)'(($signed({1'b0, cfg.j_weight}) - 13'sd256) *
				$signed({1'b0, d_q}));
		end
		if (state_q == kdj_pkg::ST_J_SUM) begin
			if (jrnd > (KB+7)'(kdj_pkg::J_LIMIT)) begin
				j_q <= kdj_pkg::J_LIMIT;
			end else if (jrnd < -(KB+7)'(kdj_pkg::J_LIMIT)) begin
				j_q <= -kdj_pkg::J_LIMIT;
			end else begin
				j_q <= JB'(jrnd);
			end
		end
		if (out_load) begin
			out_q <= res;
		end
	end

endmodule

// ----- rtl/core/kdj_stochastic_oscillator.sv -----
// ----------------------------------------------------------------------------
// kdj_stochastic_oscillator
// KDJ stochastic oscillator over a ring of recent bar highs and lows.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one price bar per item. out_valid/
//   out_stall/out_data carry one result per bar. cfg_valid/cfg_ready with
//   cfg_index/cfg_data write window_length, smoothing_length and j_weight;
//   write only while the block is idle. cfg_ready is always high.
//   A front stage takes bars into a two-entry queue; the back stage works
//   one bar at a time: a ring write, a scan of window_length entries at one
//   RAM read per cycle, and up to three divisions on one shared
//   two-bit-per-cycle divider. A bar that completes a window skips the ratio
//   division when the raw value is a fixed case; a bar before the window is
//   full skips the scan and all divisions. The back stage pops the next bar
//   only after it has loaded the result of the last one.
//   Reset clears the ring pointer, the fill count and the queue, and sets K
//   and D to 50.0; ring contents are not cleared.
//   While out_stall is high the result is held; the back stage can still
//   take one more bar and the queue two more before in_stall rises.
// ----------------------------------------------------------------------------
module kdj_stochastic_oscillator #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  kdj_pkg::bar_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output kdj_pkg::result_t                  out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [kdj_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [kdj_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	kdj_pkg::cfg_t                   cfg;
	logic [$clog2(WINDOW_MAX+1)-1:0] win_len;
	logic                            push;
	kdj_pkg::job_t                   push_job;
	logic                            pop;
	kdj_pkg::job_t                   head;
	logic                            q_full;
	logic                            q_empty;

	kdj_front #(.WINDOW_MAX(WINDOW_MAX)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.cfg(cfg), .win_len(win_len),
		.push(push), .push_job(push_job), .q_full(q_full)
	);

	kdj_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_job(push_job), .pop(pop),
		.head(head), .full(q_full), .empty(q_empty)
	);

	kdj_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg(cfg), .win_len(win_len),
		.job(head), .q_empty(q_empty), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule
